[rtl/first_fit_block_allocator_macros.svh]
// assertion helpers used by the allocator datapath
// both expect i_clk and i_rst_n in the scope of the use
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define FFBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ffba_pkg.sv]
`timescale 1ns / 1ps

package ffba_pkg;

    // sizes and fixed field widths
    localparam int POOL_UNITS_MAX_DEF = 256;
    localparam int UNIT_BYTES         = 4;
    localparam int HDR_BYTES          = 2;
    localparam int POOL_FIELD_W       = 9;
    localparam int POOL_RESET         = 256;
    localparam int REQ_W              = 8;
    localparam int OFF_W              = 10;
    localparam int UNITS_W            = 7;
    localparam int RUN_W              = 8;
    localparam int APB_DATA_W         = 32;
    localparam int APB_ADDR_W         = 3;
    localparam int IN_DATA_W          = 24;
    localparam int OUT_DATA_W         = 16;

    // register index of pool_units
    localparam logic REG_POOL_UNITS = 1'b0;

    // operation codes on the request tuser
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // sequencer steps
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ASTART,
        ST_AWALK,
        ST_AMARK,
        ST_ASPLIT,
        ST_FREE,
        ST_DONE
    } t_step;

    // jump conditions
    typedef enum logic [2:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_CLR_LAST,
        CND_ACC_ALLOC,
        CND_ACC_FREE,
        CND_FOUND,
        CND_WALK_END,
        CND_OUT_ROOM
    } t_cond;

    // header read source
    typedef enum logic [1:0] {
        RD_NONE,
        RD_ZERO,
        RD_NEXT
    } t_rd;

    // header write kind, each implies its address and data
    typedef enum logic [2:0] {
        WR_NONE,
        WR_CLEAR,
        WR_GRANT,
        WR_SPLIT,
        WR_FREE
    } t_wr;

    // datapath register operation
    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LATCH,
        OP_WALK_INIT,
        OP_WALK,
        OP_GRANT,
        OP_FREE
    } t_op;

    // one control word of the program
    typedef struct packed {
        logic  in_ready;
        logic  out_load;
        t_rd   rd;
        t_wr   wr;
        t_op   op;
        t_cond cond_a;
        t_step tgt_a;
        t_cond cond_b;
        t_step tgt_b;
        t_step tgt_c;
    } t_ctrl;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic clr_last;
        logic acc_alloc;
        logic acc_free;
        logic found;
        logic walk_end;
        logic out_room;
    } t_status;

    // program table
    function automatic t_ctrl ucode(input t_step s);
        t_ctrl c;
        c = '{in_ready: 1'b0, out_load: 1'b0, rd: RD_NONE, wr: WR_NONE, op: OP_NONE,
              cond_a: CND_ALWAYS, tgt_a: ST_IDLE, cond_b: CND_NEVER, tgt_b: ST_IDLE,
              tgt_c: ST_IDLE};
        unique case (s)
            ST_CLEAR: begin
                c.wr     = WR_CLEAR;
                c.op     = OP_CLEAR;
                c.cond_a = CND_CLR_LAST;
                c.tgt_a  = ST_IDLE;
                c.tgt_c  = ST_CLEAR;
            end
            ST_IDLE: begin
                c.in_ready = 1'b1;
                c.op       = OP_LATCH;
                c.cond_a   = CND_ACC_ALLOC;
                c.tgt_a    = ST_ASTART;
                c.cond_b   = CND_ACC_FREE;
                c.tgt_b    = ST_FREE;
                c.tgt_c    = ST_IDLE;
            end
            ST_ASTART: begin
                c.rd    = RD_ZERO;
                c.op    = OP_WALK_INIT;
                c.tgt_a = ST_AWALK;
            end
            ST_AWALK: begin
                c.rd     = RD_NEXT;
                c.op     = OP_WALK;
                c.cond_a = CND_FOUND;
                c.tgt_a  = ST_AMARK;
                c.cond_b = CND_WALK_END;
                c.tgt_b  = ST_DONE;
                c.tgt_c  = ST_AWALK;
            end
            ST_AMARK: begin
                c.wr    = WR_GRANT;
                c.tgt_a = ST_ASPLIT;
            end
            ST_ASPLIT: begin
                c.wr    = WR_SPLIT;
                c.op    = OP_GRANT;
                c.tgt_a = ST_DONE;
            end
            ST_FREE: begin
                c.wr    = WR_FREE;
                c.op    = OP_FREE;
                c.tgt_a = ST_DONE;
            end
            ST_DONE: begin
                c.out_load = 1'b1;
                c.cond_a   = CND_OUT_ROOM;
                c.tgt_a    = ST_IDLE;
                c.tgt_c    = ST_DONE;
            end
            default: begin
                c.tgt_a = ST_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

[rtl/ffba_hdr_ram.sv]
`timescale 1ns / 1ps

module ffba_hdr_ram import ffba_pkg::*; #(
    parameter int DEPTH  = POOL_UNITS_MAX_DEF,
    parameter int ADDR_W = $clog2(POOL_UNITS_MAX_DEF)
) (
    input  logic               i_clk,
    input  logic               i_rd_en,
    input  logic [ADDR_W-1:0]  i_rd_addr,
    output logic               o_rd_busy,
    output logic [UNITS_W-1:0] o_rd_units,
    input  logic               i_wr_busy_en,
    input  logic               i_wr_units_en,
    input  logic [ADDR_W-1:0]  i_wr_addr,
    input  logic               i_wr_busy,
    input  logic [UNITS_W-1:0] i_wr_units
);

    logic               mem_busy  [DEPTH];
    logic [UNITS_W-1:0] mem_units [DEPTH];

    // write port, busy mark and length written separately
    always_ff @(posedge i_clk) begin
        if (i_wr_busy_en) begin
            mem_busy[i_wr_addr] <= i_wr_busy;
        end
        if (i_wr_units_en) begin
            mem_units[i_wr_addr] <= i_wr_units;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_busy  <= mem_busy[i_rd_addr];
            o_rd_units <= mem_units[i_rd_addr];
        end
    end

endmodule

[rtl/ffba_seq.sv]
`timescale 1ns / 1ps

module ffba_seq import ffba_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_ctrl   o_ctrl
);

    t_step r_step;
    t_step n_step;

    function automatic logic cond_ok(input t_cond c, input t_status s);
        logic ok;
        unique case (c)
            CND_NEVER:     ok = 1'b0;
            CND_ALWAYS:    ok = 1'b1;
            CND_CLR_LAST:  ok = s.clr_last;
            CND_ACC_ALLOC: ok = s.acc_alloc;
            CND_ACC_FREE:  ok = s.acc_free;
            CND_FOUND:     ok = s.found;
            CND_WALK_END:  ok = s.walk_end;
            CND_OUT_ROOM:  ok = s.out_room;
            default:       ok = 1'b0;
        endcase
        return ok;
    endfunction

    // step counter, reset starts the header clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_CLEAR;
        end else begin
            r_step <= n_step;
        end
    end

    // fetch control word and pick the jump target
    always_comb begin
        o_ctrl = ucode(r_step);
        if (cond_ok(o_ctrl.cond_a, i_status)) begin
            n_step = o_ctrl.tgt_a;
        end else if (cond_ok(o_ctrl.cond_b, i_status)) begin
            n_step = o_ctrl.tgt_b;
        end else begin
            n_step = o_ctrl.tgt_c;
        end
    end

endmodule

[rtl/ffba_dp.sv]
`timescale 1ns / 1ps

module ffba_dp import ffba_pkg::*; #(
    parameter int POOL_UNITS_MAX = POOL_UNITS_MAX_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  t_ctrl                                      i_ctrl,
    output t_status                                    o_status,
    input  logic [$clog2(POOL_UNITS_MAX + 128)-1:0]    i_pool_units,
    input  logic                                       i_in_valid,
    output logic                                       o_in_ready,
    input  logic                                       i_in_func,
    input  logic [REQ_W-1:0]                           i_in_req,
    input  logic [OFF_W-1:0]                           i_in_off,
    output logic                                       o_out_valid,
    input  logic                                       i_out_ready,
    output logic                                       o_out_granted,
    output logic [OFF_W-1:0]                           o_out_off,
    output logic                                       o_rd_en,
    output logic [$clog2(POOL_UNITS_MAX)-1:0]          o_rd_addr,
    input  logic                                       i_rd_busy,
    input  logic [UNITS_W-1:0]                         i_rd_units,
    output logic                                       o_wr_busy_en,
    output logic                                       o_wr_units_en,
    output logic [$clog2(POOL_UNITS_MAX)-1:0]          o_wr_addr,
    output logic                                       o_wr_busy,
    output logic [UNITS_W-1:0]                         o_wr_units
);

    `include "first_fit_block_allocator_macros.svh"

    localparam int IDX_W = $clog2(POOL_UNITS_MAX);
    localparam int CNT_W = $clog2(POOL_UNITS_MAX + 128);

    logic [IDX_W-1:0]   r_clr;
    logic [UNITS_W-1:0] r_need;
    logic [OFF_W-1:0]   r_off;
    logic [CNT_W-1:0]   r_i;
    logic [RUN_W-1:0]   r_run;
    logic [IDX_W-1:0]   r_start;
    logic               r_granted;
    logic [OFF_W-1:0]   r_res_off;
    logic               r_out_valid;
    logic               r_out_granted;
    logic [OFF_W-1:0]   r_out_off;

    logic               accept;
    logic [UNITS_W-1:0] need_in;
    logic [UNITS_W-1:0] units_eff;
    logic [CNT_W-1:0]   avail;
    logic [RUN_W-1:0]   take;
    logic [RUN_W-1:0]   run_sum;
    logic [RUN_W-1:0]   run_cur;
    logic [IDX_W-1:0]   start_cur;
    logic               found;
    logic [CNT_W-1:0]   i_next;
    logic [CNT_W-1:0]   split_sum;
    logic               split_ok;
    logic [UNITS_W-1:0] remain;
    logic               free_ok;
    logic [OFF_W-1:0]   grant_off;
    logic               room;

    // request handshake and unit count with header, rounded up
    assign accept     = i_ctrl.in_ready & i_in_valid;
    assign o_in_ready = i_ctrl.in_ready;
    assign need_in    = UNITS_W'((9'(i_in_req) + 9'(HDR_BYTES + UNIT_BYTES - 1)) / UNIT_BYTES);

    // one header per cycle of the first-fit walk
    always_comb begin
        units_eff = (i_rd_units == '0) ? UNITS_W'(1) : i_rd_units;
        avail     = i_pool_units - r_i;
        take      = (CNT_W'(units_eff) < avail) ? RUN_W'(units_eff) : RUN_W'(avail);
        run_sum   = r_run + take;
        run_cur   = i_rd_busy ? '0 : run_sum;
        start_cur = (r_run == '0) ? r_i[IDX_W-1:0] : r_start;
        found     = !i_rd_busy && (run_sum >= RUN_W'(r_need));
        i_next    = r_i + CNT_W'(units_eff);
    end

    // surplus split, grant offset and free checks
    always_comb begin
        split_sum = CNT_W'(r_start) + CNT_W'(r_need);
        split_ok  = (r_run > RUN_W'(r_need)) && (split_sum < CNT_W'(POOL_UNITS_MAX));
        remain    = UNITS_W'(r_run - RUN_W'(r_need));
        grant_off = OFF_W'((32'(r_start) * UNIT_BYTES) + HDR_BYTES);
        free_ok   = (r_off[1:0] == 2'(HDR_BYTES))
                    && (32'(r_off[OFF_W-1:2]) < 32'(i_pool_units));
    end

    // flags for the sequencer
    assign room = !r_out_valid || i_out_ready;
    always_comb begin
        o_status.clr_last  = (r_clr == IDX_W'(POOL_UNITS_MAX - 1));
        o_status.acc_alloc = accept && (i_in_func == FUNC_ALLOC);
        o_status.acc_free  = accept && (i_in_func == FUNC_FREE);
        o_status.found     = found;
        o_status.walk_end  = !found && (i_next >= i_pool_units);
        o_status.out_room  = room;
    end

    // header read address
    always_comb begin
        o_rd_en   = 1'b0;
        o_rd_addr = '0;
        case (i_ctrl.rd)
            RD_ZERO: begin
                o_rd_en = 1'b1;
            end
            RD_NEXT: begin
                o_rd_en   = 1'b1;
                o_rd_addr = i_next[IDX_W-1:0];
            end
            default: begin
                o_rd_en = 1'b0;
            end
        endcase
    end

    // header writes
    always_comb begin
        o_wr_busy_en  = 1'b0;
        o_wr_units_en = 1'b0;
        o_wr_addr     = r_start;
        o_wr_busy     = 1'b0;
        o_wr_units    = r_need;
        case (i_ctrl.wr)
            WR_CLEAR: begin
                o_wr_busy_en  = 1'b1;
                o_wr_units_en = 1'b1;
                o_wr_addr     = r_clr;
                o_wr_units    = UNITS_W'(1);
            end
            WR_GRANT: begin
                o_wr_busy_en  = 1'b1;
                o_wr_units_en = 1'b1;
                o_wr_busy     = 1'b1;
            end
            WR_SPLIT: begin
                o_wr_busy_en  = split_ok;
                o_wr_units_en = split_ok;
                o_wr_addr     = split_sum[IDX_W-1:0];
                o_wr_units    = remain;
            end
            WR_FREE: begin
                o_wr_busy_en = free_ok;
                o_wr_addr    = IDX_W'(r_off[OFF_W-1:2]);
            end
            default: begin
                o_wr_busy_en = 1'b0;
            end
        endcase
    end

    // control registers: clear pointer and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.op == OP_CLEAR) begin
                r_clr <= r_clr + IDX_W'(1);
            end
            if (i_ctrl.out_load && room) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers of the current request
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            OP_LATCH: begin
                if (accept) begin
                    r_need <= need_in;
                    r_off  <= i_in_off;
                end
            end
            OP_WALK_INIT: begin
                r_i       <= '0;
                r_run     <= '0;
                r_start   <= '0;
                r_granted <= 1'b0;
                r_res_off <= '0;
            end
            OP_WALK: begin
                r_i   <= i_next;
                r_run <= run_cur;
                if (!i_rd_busy) begin
                    r_start <= start_cur;
                end
            end
            OP_GRANT: begin
                r_granted <= 1'b1;
                r_res_off <= grant_off;
            end
            OP_FREE: begin
                r_granted <= free_ok;
                r_res_off <= '0;
            end
            default: begin
                r_granted <= r_granted;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load && room) begin
            r_out_granted <= r_granted;
            r_out_off     <= r_res_off;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_granted = r_out_granted;
    assign o_out_off     = r_out_off;

    `FFBA_ASSERT_NOW(a_walk_in_pool, i_ctrl.op == OP_WALK, r_i < i_pool_units, "walk left pool")
    `FFBA_ASSERT_NOW(a_walk_short, i_ctrl.op == OP_WALK, r_run < RUN_W'(r_need), "walk overran need")
    `FFBA_ASSERT_NOW(a_refused_zero, r_out_valid && !r_out_granted, r_out_off == '0, "refused offset")
    `FFBA_ASSERT_NEXT(a_grant_split, i_ctrl.wr == WR_GRANT, i_ctrl.wr == WR_SPLIT, "no split step")

endmodule

[rtl/first_fit_block_allocator.sv]
`timescale 1ns / 1ps

// channel    dir  handshake                      payload
// s_axis     in   s_axis_tvalid / s_axis_tready  tuser func, tdata request_bytes, payload_offset
// m_axis     out  m_axis_tvalid / m_axis_tready  tuser granted, tdata result_offset
// apb        in   psel, penable, pwrite, pready  pool_units at byte address 0
//
// after reset the header store is swept, one entry a cycle, no requests
// a free passes through the free and done steps from acceptance to result
// an allocate walks k headers (up to pool_units), then marks and splits when granted or goes
// straight to done when refused; the walk reads one header per cycle from the header ram
// one request at a time; a finished result waits in the output register while the next
// request is accepted; the sequencer holds in its done step only while an earlier result
// still waits there and m_axis_tready is low
module first_fit_block_allocator import ffba_pkg::*; #(
    parameter int POOL_UNITS_MAX = POOL_UNITS_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // request_bytes[7:0], payload_offset[17:8]
    input  logic [0:0]            s_axis_tuser,   // func[0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // result_offset[9:0]
    output logic [0:0]            m_axis_tuser,   // granted[0]
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = $clog2(POOL_UNITS_MAX);
    localparam int CNT_W = $clog2(POOL_UNITS_MAX + 128);

    logic [CNT_W-1:0]   r_pool_units;
    logic [CNT_W-1:0]   n_pool_units;
    logic [31:0]        wr_val;

    t_ctrl              ctrl;
    t_status            status;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               rd_busy;
    logic [UNITS_W-1:0] rd_units;
    logic               wr_busy_en;
    logic               wr_units_en;
    logic [IDX_W-1:0]   wr_addr;
    logic               wr_busy;
    logic [UNITS_W-1:0] wr_units;
    logic               out_granted;
    logic [OFF_W-1:0]   out_off;

    // pool size write, saturated to 1..POOL_UNITS_MAX
    always_comb begin
        wr_val = 32'(pwdata[POOL_FIELD_W-1:0]);
        if (wr_val == 32'd0) begin
            n_pool_units = CNT_W'(1);
        end else if (wr_val > 32'(POOL_UNITS_MAX)) begin
            n_pool_units = CNT_W'(POOL_UNITS_MAX);
        end else begin
            n_pool_units = CNT_W'(wr_val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_units <= CNT_W'((POOL_RESET < POOL_UNITS_MAX) ? POOL_RESET : POOL_UNITS_MAX);
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_POOL_UNITS)) begin
            r_pool_units <= n_pool_units;
        end
    end

    // register readback
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_POOL_UNITS) ? APB_DATA_W'(r_pool_units) : '0;

    ffba_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    ffba_dp #(
        .POOL_UNITS_MAX (POOL_UNITS_MAX)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .o_status      (status),
        .i_pool_units  (r_pool_units),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_in_func     (s_axis_tuser[0]),
        .i_in_req      (s_axis_tdata[REQ_W-1:0]),
        .i_in_off      (s_axis_tdata[REQ_W+OFF_W-1:REQ_W]),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_granted (out_granted),
        .o_out_off     (out_off),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_busy     (rd_busy),
        .i_rd_units    (rd_units),
        .o_wr_busy_en  (wr_busy_en),
        .o_wr_units_en (wr_units_en),
        .o_wr_addr     (wr_addr),
        .o_wr_busy     (wr_busy),
        .o_wr_units    (wr_units)
    );

    ffba_hdr_ram #(
        .DEPTH  (POOL_UNITS_MAX),
        .ADDR_W (IDX_W)
    ) u_hdr_ram (
        .i_clk         (i_clk),
        .i_rd_en       (rd_en),
        .i_rd_addr     (rd_addr),
        .o_rd_busy     (rd_busy),
        .o_rd_units    (rd_units),
        .i_wr_busy_en  (wr_busy_en),
        .i_wr_units_en (wr_units_en),
        .i_wr_addr     (wr_addr),
        .i_wr_busy     (wr_busy),
        .i_wr_units    (wr_units)
    );

    // result packing
    assign m_axis_tdata = OUT_DATA_W'(out_off);
    assign m_axis_tuser = out_granted;

endmodule

[dv/tb_first_fit_block_allocator.sv]
`timescale 1ns / 1ps

module tb_first_fit_block_allocator;
    import ffba_pkg::*;

    // expected reply of one request
    typedef struct packed {
        logic             granted;
        logic [OFF_W-1:0] offset;
    } t_reply;

    // header store mirror, pool size and the replies still owed by the block
    class alloc_scoreboard;
        bit               hdr_busy[POOL_UNITS_MAX_DEF];
        bit [UNITS_W-1:0] hdr_units[POOL_UNITS_MAX_DEF];
        int               pool;
        t_reply           replies[$];
        int               held_offsets[$];
        int               errors;

        function new();
            pool   = POOL_RESET;
            errors = 0;
            for (int k = 0; k < POOL_UNITS_MAX_DEF; k++) begin
                hdr_busy[k]  = 1'b0;
                hdr_units[k] = 7'd1;
            end
        endfunction

        // register write, saturated into 1..max
        function void set_pool(input logic [APB_DATA_W-1:0] value);
            int v;
            v = int'(value[POOL_FIELD_W-1:0]);
            if (v < 1)
                v = 1;
            if (v > POOL_UNITS_MAX_DEF)
                v = POOL_UNITS_MAX_DEF;
            pool = v;
        endfunction

        // first-fit walk with merging of free neighbors
        function t_reply predict_alloc(input logic [REQ_W-1:0] req);
            t_reply r;
            int     need;
            int     i;
            int     start;
            int     run;
            int     u;
            int     avail;
            bit     found;
            need  = (int'(req) + HDR_BYTES + UNIT_BYTES - 1) / UNIT_BYTES;
            i     = 0;
            start = 0;
            run   = 0;
            found = 1'b0;
            r     = '0;
            while (i < pool && !found) begin
                u = int'(hdr_units[i]);
                if (u == 0)
                    u = 1;
                if (hdr_busy[i]) begin
                    run = 0;
                end else begin
                    avail = pool - i;
                    if (run == 0)
                        start = i;
                    run += (u < avail) ? u : avail;
                    if (run >= need)
                        found = 1'b1;
                end
                i += u;
            end
            if (found) begin
                hdr_busy[start]  = 1'b1;
                hdr_units[start] = UNITS_W'(need);
                // surplus gets its own free header
                if (run > need && start + need < POOL_UNITS_MAX_DEF) begin
                    hdr_busy[start + need]  = 1'b0;
                    hdr_units[start + need] = UNITS_W'(run - need);
                end
                r.granted = 1'b1;
                r.offset  = OFF_W'(start * UNIT_BYTES + HDR_BYTES);
                held_offsets.push_back(int'(r.offset));
            end
            return r;
        endfunction

        // free clears the busy mark if the offset is header-aligned and its unit lies in the pool
        function t_reply predict_free(input logic [OFF_W-1:0] off);
            t_reply r;
            int     unit_idx;
            r = '0;
            if (off[1:0] == 2'd2) begin
                unit_idx = (int'(off) - HDR_BYTES) / UNIT_BYTES;
                if (unit_idx < pool) begin
                    hdr_busy[unit_idx] = 1'b0;
                    r.granted = 1'b1;
                    for (int k = held_offsets.size() - 1; k >= 0; k--)
                        if (held_offsets[k] == int'(off))
                            held_offsets.delete(k);
                end
            end
            return r;
        endfunction

        function void note_request(input logic fn, input logic [REQ_W-1:0] req,
                                   input logic [OFF_W-1:0] off);
            if (fn == FUNC_ALLOC)
                replies.push_back(predict_alloc(req));
            else
                replies.push_back(predict_free(off));
        endfunction

        task report_mismatch(input string what, input int got, input int want);
            errors++;
            $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
        endtask

        task check_result(input logic granted, input logic [OFF_W-1:0] offset);
            t_reply want;
            if (replies.size() == 0) begin
                report_mismatch("unexpected reply, granted", int'(granted), -1);
            end else begin
                want = replies.pop_front();
                if (granted !== want.granted)
                    report_mismatch("granted", int'(granted), int'(want.granted));
                if (offset !== want.offset)
                    report_mismatch("result_offset", int'(offset), int'(want.offset));
            end
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;    // request_bytes[7:0], payload_offset[17:8]
    logic [0:0]            s_axis_tuser;    // func[0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;    // result_offset[9:0]
    logic [0:0]            m_axis_tuser;    // granted[0]
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    alloc_scoreboard sb = new();
    bit              calm = 1'b0;

    first_fit_block_allocator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 12 ns clock
    always #6 i_clk = ~i_clk;

    // reply checking at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser[0], m_axis_tdata[OFF_W-1:0]);
    end

    // receiver back-pressure in random bursts
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 9) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // one request, starting and ending at a falling edge
    task automatic send_request(input logic fn, input logic [REQ_W-1:0] req,
                                input logic [OFF_W-1:0] off);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W - OFF_W - REQ_W){1'b0}}, off, req};
        s_axis_tuser  <= fn;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(fn, req, off);
        @(negedge i_clk);
    endtask

    task automatic send_alloc(input int req);
        send_request(FUNC_ALLOC, REQ_W'(req), OFF_W'($urandom_range(0, 1023)));
    endtask

    task automatic send_free(input int off);
        send_request(FUNC_FREE, REQ_W'($urandom_range(0, 255)), OFF_W'(off));
    endtask

    // drain all replies so the block is idle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.replies.size() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // apb write of pool_units, setup then access
    task automatic write_pool(input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({REG_POOL_UNITS, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_pool(value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly alloc/free pairs of held blocks, some stray frees
    task automatic random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            if ($urandom_range(0, 3) == 0)
                send_alloc($urandom_range(0, 255));
            else
                send_alloc($urandom_range(0, 40));
        end else if (pick < 85 && sb.held_offsets.size() > 0) begin
            send_free(sb.held_offsets[$urandom_range(0, sb.held_offsets.size() - 1)]);
        end else if (pick < 93) begin
            send_free($urandom_range(0, 1023));
        end else begin
            send_free($urandom_range(0, 255) * UNIT_BYTES + HDR_BYTES);
        end
    endtask

    initial begin
        logic [APB_DATA_W-1:0] pool_plan[5];
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // full pool: smallest and largest requests, freeing and re-merging
        send_alloc(0);
        send_alloc(255);
        send_alloc(1);
        send_free(6);
        send_free(6);        // repeated free
        send_free(10);       // position inside a block
        send_free(7);        // offset not on a header
        send_free(1023);
        send_free(1022);     // last unit of the pool
        send_alloc(200);     // leaves a surplus header
        send_alloc(50);
        send_alloc(6);
        send_free(2);
        send_alloc(0);
        settle();

        // write of zero saturates to a one-unit pool
        write_pool('0);
        send_alloc(0);       // only unit busy, refused
        send_free(6);        // header beyond the pool
        send_free(2);
        send_alloc(1);
        send_alloc(2);       // pool end reached
        settle();

        // block cut by the pool end
        write_pool(70);
        send_free(258);
        send_alloc(255);
        settle();
        write_pool(65);
        send_alloc(6);
        send_alloc(0);
        settle();
        write_pool(511);     // saturates to the maximum

        // random phases over several pool sizes, the last without idling
        pool_plan[0] = 256;
        pool_plan[1] = $urandom_range(2, 255);
        pool_plan[2] = 4;
        pool_plan[3] = 300;
        pool_plan[4] = 256;
        for (int ph = 0; ph < 5; ph++) begin
            settle();
            write_pool(pool_plan[ph]);
            calm = (ph == 4);
            repeat (100) random_request();
        end

        // drain and let the block go quiet
        s_axis_tvalid <= 1'b0;
        while (sb.replies.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.replies.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
